// ===== rtl/brt_pkg.sv =====
// Shared types and constants for the breakpoint range table.
`default_nettype none
package brt_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int ADDR_W  = 32;
	localparam int LAST_IDX = ENTRIES - 1;

	typedef enum logic [1:0] {
		ACT_ADD   = 2'd0,
		ACT_DEL   = 2'd1,
		ACT_CHECK = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RESP
	} state_t;

	typedef struct packed {
		action_t             action;
		logic                slot_vld;
		logic [ADDR_W-1:0]   slot_start;
		logic [ADDR_W-1:0]   slot_span;
		logic [ADDR_W-1:0]   probe;
	} cmp_req_t;

endpackage
`default_nettype wire

// ===== rtl/brt_slot_mem.sv =====
// Slot storage for range start and span, one write and one registered read port.
`default_nettype none
module brt_slot_mem (
	input  wire logic                        clk,
	input  wire logic                        wr_en,
	input  wire logic [brt_pkg::IDX_W-1:0]   wr_idx,
	input  wire logic [brt_pkg::ADDR_W-1:0]  wr_start,
	input  wire logic [brt_pkg::ADDR_W-1:0]  wr_span,
	input  wire logic [brt_pkg::IDX_W-1:0]   rd_idx,
	output logic      [brt_pkg::ADDR_W-1:0]  rd_start,
	output logic      [brt_pkg::ADDR_W-1:0]  rd_span
);

	logic [2*brt_pkg::ADDR_W-1:0] mem [brt_pkg::ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= {wr_span, wr_start};
		end
	end

	always_ff @(posedge clk) begin
		{rd_span, rd_start} <= mem[rd_idx];
	end

endmodule
`default_nettype wire

// ===== rtl/brt_cmp.sv =====
// Shared slot compare unit: free-slot, start-match and range-cover tests.
`default_nettype none
module brt_cmp (
	input  wire brt_pkg::cmp_req_t req,
	output logic                   match
);

	logic [brt_pkg::ADDR_W-1:0] range_end;

	assign range_end = req.slot_start + req.slot_span;

	always_comb begin
		unique case (req.action)
			brt_pkg::ACT_ADD:   match = !req.slot_vld;
			brt_pkg::ACT_DEL:   match = req.slot_vld && (req.slot_start == req.probe);
			brt_pkg::ACT_CHECK: match = req.slot_vld && (req.probe >= req.slot_start)
			                            && (req.probe <= range_end);
			default:            match = 1'b0;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/breakpoint_range_table.sv =====
// Top level of the breakpoint range table: sequencer, valid bits and result register.
// Each item (add, delete or check) scans the slot table one slot per cycle
// through a single memory read port and one shared compare unit, stopping at
// the first matching slot. An item passes through the slot reads, the registered
// read, the result state and an idle state before the next is accepted; a delete
// on an empty table and the unused action code skip the scan and go straight to
// the result. Output stalls hold the block in the result state.
// The result is held on the output until taken, and the next item is accepted
// in the cycle after it has been taken.
`default_nettype none
module breakpoint_range_table (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,  // action[1:0], address[33:2], span[65:34], zero pad
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata   // hit[0], status[2:1], entries_in_use[7:3]
);

	localparam int IW = brt_pkg::IDX_W;
	localparam int CW = brt_pkg::CNT_W;
	localparam int AW = brt_pkg::ADDR_W;

	brt_pkg::state_t  state_q, state_nxt;
	brt_pkg::action_t act_q;
	logic [AW-1:0]    addr_q, span_q;
	logic [IW-1:0]    idx_q, idx_s1;
	logic             issue_q, pend_s1;
	logic [brt_pkg::ENTRIES-1:0] valid_q;
	logic [CW-1:0]    count_q;
	logic             hit_q;
	brt_pkg::status_t status_q;

	logic [AW-1:0]    rd_start, rd_span;
	logic             match;
	brt_pkg::cmp_req_t cmp_req;
	logic             in_acc, eval, found, scan_end, wr_en;
	brt_pkg::action_t in_act;
	logic [CW+4:0]    count_ext;

	assign in_act = brt_pkg::action_t'(s_tdata[1:0]);
	assign in_acc = s_tvalid && s_tready;

	assign cmp_req.action     = act_q;
	assign cmp_req.slot_vld   = valid_q[idx_s1];
	assign cmp_req.slot_start = rd_start;
	assign cmp_req.slot_span  = rd_span;
	assign cmp_req.probe      = addr_q;

	brt_cmp u_cmp (
		.req   (cmp_req),
		.match (match)
	);

	brt_slot_mem u_mem (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_idx   (idx_s1),
		.wr_start (addr_q),
		.wr_span  (span_q),
		.rd_idx   (idx_q),
		.rd_start (rd_start),
		.rd_span  (rd_span)
	);

	always_comb begin
		s_tready = (state_q == brt_pkg::S_IDLE);
		m_tvalid = (state_q == brt_pkg::S_RESP);
		eval     = (state_q == brt_pkg::S_SCAN) && pend_s1;
		found    = eval && match;
		scan_end = eval && (found || (idx_s1 == IW'(brt_pkg::LAST_IDX)));
		wr_en    = found && (act_q == brt_pkg::ACT_ADD);
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			brt_pkg::S_IDLE: begin
				if (s_tvalid) begin
					priority if (in_act == brt_pkg::ACT_DEL && count_q == '0)
						state_nxt = brt_pkg::S_RESP;
					else if (in_act == brt_pkg::ACT_ADD || in_act == brt_pkg::ACT_DEL
					         || in_act == brt_pkg::ACT_CHECK)
						state_nxt = brt_pkg::S_SCAN;
					else
						state_nxt = brt_pkg::S_RESP;
				end
			end
			brt_pkg::S_SCAN: begin
				if (scan_end) state_nxt = brt_pkg::S_RESP;
			end
			brt_pkg::S_RESP: begin
				if (m_tready) state_nxt = brt_pkg::S_IDLE;
			end
			default: state_nxt = brt_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= brt_pkg::S_IDLE;
			valid_q <= '0;
			count_q <= '0;
			issue_q <= 1'b0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (in_acc) begin
				issue_q <= 1'b1;
				pend_s1 <= 1'b0;
			end else if (state_q == brt_pkg::S_SCAN) begin
				pend_s1 <= issue_q;
				if (idx_q == IW'(brt_pkg::LAST_IDX)) issue_q <= 1'b0;
			end
			if (found) begin
				unique case (act_q)
					brt_pkg::ACT_ADD: begin
						valid_q[idx_s1] <= 1'b1;
						count_q         <= count_q + CW'(1);
					end
					brt_pkg::ACT_DEL: begin
						valid_q[idx_s1] <= 1'b0;
						count_q         <= count_q - CW'(1);
					end
					default: ;
				endcase
			end
		end
	end

	// payload and scan index
	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q    <= in_act;
			addr_q   <= s_tdata[33:2];
			span_q   <= s_tdata[65:34];
			idx_q    <= '0;
			hit_q    <= 1'b0;
			status_q <= (in_act == brt_pkg::ACT_DEL && count_q == '0) ?
			            brt_pkg::ST_EMPTY : brt_pkg::ST_OK;
		end else if (state_q == brt_pkg::S_SCAN) begin
			idx_s1 <= idx_q;
			if (idx_q != IW'(brt_pkg::LAST_IDX)) idx_q <= idx_q + IW'(1);
			if (found) begin
				hit_q    <= (act_q == brt_pkg::ACT_CHECK);
				status_q <= brt_pkg::ST_OK;
			end else if (scan_end) begin
				hit_q <= 1'b0;
				unique case (act_q)
					brt_pkg::ACT_ADD: status_q <= brt_pkg::ST_FULL;
					brt_pkg::ACT_DEL: status_q <= brt_pkg::ST_NOT_FOUND;
					default:          status_q <= brt_pkg::ST_OK;
				endcase
			end
		end
	end

	assign count_ext = {5'd0, count_q};
	assign m_tdata   = {count_ext[4:0], status_q, hit_q};

endmodule
`default_nettype wire

// ===== verif/tb_breakpoint_range_table.sv =====
// Testbench for breakpoint_range_table: directed table, then random items against a predictor.
`timescale 1ns / 1ps
module tb_breakpoint_range_table;
	import brt_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int N_RANDOM  = 1900;
	localparam int LATENCY   = ENTRIES + 2;
	localparam int HOLD_AT   = 400;
	localparam int HOLD_LEN  = 300;
	localparam int PAUSE_AT  = 900;
	localparam int CALM_FROM = 1200;
	localparam int CALM_TO   = 1450;

	typedef struct packed {
		logic       hit;
		status_t    status;
		logic [4:0] count;
	} bp_result_t;

	typedef struct packed {
		logic [1:0]  act;
		logic [31:0] addr;
		logic [31:0] span;
		logic [4:0]  reps;
		logic        typed;
		bp_result_t  res;
	} bp_row_t;

	localparam int N_ROWS = 26;

	bp_row_t directed_rows [0:N_ROWS-1] = '{
		'{ACT_DEL,    32'h0000_0000, 32'h0000_0000, 5'd1,  1'b1, '{1'b0, ST_EMPTY, 5'd0}},
		'{ACT_CHECK,  32'h0000_0000, 32'h0000_0000, 5'd1,  1'b1, '{1'b0, ST_OK, 5'd0}},
		'{ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1,  1'b1, '{1'b0, ST_OK, 5'd0}},
		'{ACT_ADD,    32'h0000_1000, 32'h0000_0010, 5'd1,  1'b1, '{1'b0, ST_OK, 5'd1}},
		'{ACT_CHECK,  32'h0000_1000, 32'hFFFF_FFFF, 5'd1,  1'b0, '{1'b0, ST_OK, 5'd0}},
		'{ACT_CHECK,  32'h0000_1010, 32'h0000_0000, 5'd1,  1'b0, '{1'b0, ST_OK, 5'd0}},
		'{ACT_CHECK,  32'h0000_1011, 32'h0000_0000, 5'd1,  1'b0, '{1'b0, ST_OK, 5'd0}},
		'{ACT_CHECK,  32'h0000_0FFF, 32'h0000_0000, 5'd1,  1'b0, '{1'b0, ST_OK, 5'd0}},
		'{ACT_ADD,    32'hFFFF_FFF0, 32'h0000_0020, 5'd1,  1'b0, '{1'b0, ST_OK, 5'd0}},
		'{ACT_CHECK,  32'hFFFF_FFF8, 32'h0000_0000, 5'd1,  1'b0, '{1'b0, ST_OK, 5'd0}},
		'{ACT_ADD,    32'h0000_0000, 32'h0000_0000, 5'd1,  1'b0, '{1'b0, ST_OK, 5'd0}},
		'{ACT_CHECK,  32'h0000_0000, 32'h0000_0000, 5'd1,  1'b0, '{1'b0, ST_OK, 5'd0}},
		'{ACT_ADD,    32'hFFFF_FFFF, 32'h0000_0000, 5'd1,  1'b0, '{1'b0, ST_OK, 5'd0}},
		'{ACT_CHECK,  32'hFFFF_FFFF, 32'h0000_0000, 5'd1,  1'b0, '{1'b0, ST_OK, 5'd0}},
		'{ACT_ADD,    32'h0000_1000, 32'h0000_FFFF, 5'd1,  1'b0, '{1'b0, ST_OK, 5'd0}},
		'{ACT_DEL,    32'h0000_1000, 32'h0000_0000, 5'd1,  1'b0, '{1'b0, ST_OK, 5'd0}},
		'{ACT_CHECK,  32'h0000_1800, 32'h0000_0000, 5'd1,  1'b0, '{1'b0, ST_OK, 5'd0}},
		'{ACT_DEL,    32'h0000_2222, 32'h0000_0000, 5'd1,  1'b0, '{1'b0, ST_OK, 5'd0}},
		'{ACT_ADD,    32'hA5A5_A5A5, 32'h5A5A_5A5A, 5'd13, 1'b0, '{1'b0, ST_OK, 5'd0}},
		'{ACT_CHECK,  32'h5555_5555, 32'h0000_0000, 5'd1,  1'b0, '{1'b0, ST_OK, 5'd0}},
		'{ACT_ADD,    32'h0000_0000, 32'hFFFF_FFFF, 5'd1,  1'b0, '{1'b0, ST_OK, 5'd0}},
		'{ACT_DEL,    32'hA5A5_A5A5, 32'h0000_0000, 5'd12, 1'b0, '{1'b0, ST_OK, 5'd0}},
		'{ACT_ADD,    32'h0000_0000, 32'hFFFF_FFFF, 5'd1,  1'b0, '{1'b0, ST_OK, 5'd0}},
		'{ACT_CHECK,  32'h5555_5555, 32'h0000_0000, 5'd1,  1'b0, '{1'b0, ST_OK, 5'd0}},
		'{ACT_DEL,    32'h0000_0000, 32'h0000_0000, 5'd2,  1'b0, '{1'b0, ST_OK, 5'd0}},
		'{ACT_DEL,    32'h0000_0000, 32'h0000_0000, 5'd1,  1'b0, '{1'b0, ST_OK, 5'd0}}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;  // action[1:0], address[33:2], span[65:34], zero pad
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;      // hit[0], status[2:1], entries_in_use[7:3]

	// breakpoint table as the block should hold it
	logic        bp_live  [ENTRIES];
	logic [31:0] bp_start [ENTRIES];
	logic [31:0] bp_span  [ENTRIES];
	logic [4:0]  bp_count;

	bp_result_t  pending_results [$];
	logic        row_typed = 1'b0;
	bp_result_t  row_result = '0;
	logic        calm = 1'b0;
	int unsigned results_taken = 0;
	int unsigned mismatches = 0;
	int unsigned hold_left = 0;
	logic        hold_done = 1'b0;

	breakpoint_range_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic bp_result_t predict_table_result(input logic [1:0] act,
			input logic [31:0] addr, input logic [31:0] span);
		bp_result_t  r;
		logic [31:0] last;
		r = '{1'b0, ST_OK, 5'd0};
		if (act == ACT_ADD) begin
			r.status = ST_FULL;
			for (int i = 0; i < ENTRIES; i++) begin
				if (!bp_live[i]) begin
					bp_live[i]  = 1'b1;
					bp_start[i] = addr;
					bp_span[i]  = span;
					bp_count    = bp_count + 5'd1;
					r.status    = ST_OK;
					break;
				end
			end
		end else if (act == ACT_DEL) begin
			if (bp_count == 5'd0) begin
				r.status = ST_EMPTY;
			end else begin
				r.status = ST_NOT_FOUND;
				for (int i = 0; i < ENTRIES; i++) begin
					if (bp_live[i] && bp_start[i] == addr) begin
						bp_live[i] = 1'b0;
						bp_count   = bp_count - 5'd1;
						r.status   = ST_OK;
						break;
					end
				end
			end
		end else if (act == ACT_CHECK) begin
			for (int i = 0; i < ENTRIES; i++) begin
				last = bp_start[i] + bp_span[i];
				if (bp_live[i] && addr >= bp_start[i] && addr <= last) begin
					r.hit = 1'b1;
					break;
				end
			end
		end
		r.count = bp_count;
		return r;
	endfunction

	// mostly well-formed traffic: deletes of stored starts, probes at range edges
	task automatic pick_item(input logic fill_bias, output logic [1:0] act,
			output logic [31:0] addr, output logic [31:0] span);
		int live_idx [$];
		int sel;
		int roll;
		for (int i = 0; i < ENTRIES; i++)
			if (bp_live[i])
				live_idx.push_back(i);
		roll = $urandom_range(99);
		if (roll < 3)
			act = ACT_UNUSED;
		else if (roll < (fill_bias ? 55 : 30))
			act = ACT_ADD;
		else if (roll < (fill_bias ? 72 : 70))
			act = ACT_DEL;
		else
			act = ACT_CHECK;
		addr = $urandom();
		span = $urandom();
		sel = (live_idx.size() != 0) ? live_idx[$urandom_range(live_idx.size() - 1)] : 0;
		case (act)
			ACT_ADD: begin
				case ($urandom_range(9))
					0, 1, 2: addr = 32'($urandom_range(7)) << 12;
					3:       addr = ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0;
					default: ;
				endcase
				case ($urandom_range(9))
					0:       span = 32'h0;
					1:       span = 32'hFFFF_FFFF;
					2, 3:    ;
					default: span = 32'($urandom_range(255));
				endcase
			end
			ACT_DEL: begin
				if (live_idx.size() != 0 && $urandom_range(99) < 75)
					addr = bp_start[sel];
				else if ($urandom_range(1) != 0)
					addr = 32'($urandom_range(7)) << 12;
			end
			ACT_CHECK: begin
				if (live_idx.size() != 0 && $urandom_range(99) < 70) begin
					case ($urandom_range(4))
						0: addr = bp_start[sel];
						1: addr = bp_start[sel] + bp_span[sel];
						2: addr = bp_start[sel] - 32'd1;
						3: addr = bp_start[sel] + bp_span[sel] + 32'd1;
						default: addr = bp_start[sel] + $urandom_range(bp_span[sel]);
					endcase
				end
			end
			default: ;
		endcase
	endtask

	// call at a falling edge; returns at the rising edge that takes the item
	task automatic offer_item(input logic [1:0] act, input logic [31:0] addr,
			input logic [31:0] span);
		while (!calm && $urandom_range(99) < 20) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, span, addr, act};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		bp_result_t predicted;
		if (arst_n && s_tvalid && s_tready) begin
			predicted = predict_table_result(s_tdata[1:0], s_tdata[33:2], s_tdata[65:34]);
			pending_results.push_back(row_typed ? row_result : predicted);
		end
	end

	always @(posedge clk) begin
		bp_result_t want;
		bp_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			results_taken++;
			got = '{m_tdata[0], status_t'(m_tdata[2:1]), m_tdata[7:3]};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing expected: hit=%0d status=%s count=%0d",
						$realtime, got.hit, got.status.name(), got.count);
			end else begin
				want = pending_results.pop_front();
				if (got.hit !== want.hit || got.status !== want.status ||
						got.count !== want.count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result %0d: expected %0d/%s/%0d, got %0d/%s/%0d",
							$realtime, results_taken, want.hit, want.status.name(),
							want.count, got.hit, got.status.name(), got.count);
				end
			end
		end
	end

	// result side: random stalls, one long hold-off, quiet during the calm stretch
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left != 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (!hold_done && results_taken >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= calm || ($urandom_range(99) >= 20);
			end
		end
	end

	initial begin
		logic [1:0]  act;
		logic [31:0] addr;
		logic [31:0] span;
		logic        fill_bias;
		int          drain_wait;
		for (int i = 0; i < ENTRIES; i++) begin
			bp_live[i]  = 1'b0;
			bp_start[i] = '0;
			bp_span[i]  = '0;
		end
		bp_count  = '0;
		fill_bias = 1'b1;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		for (int r = 0; r < N_ROWS; r++) begin
			for (int k = 0; k < directed_rows[r].reps; k++) begin
				@(negedge clk);
				row_typed  <= directed_rows[r].typed;
				row_result <= directed_rows[r].res;
				offer_item(directed_rows[r].act, directed_rows[r].addr, directed_rows[r].span);
			end
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == PAUSE_AT) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				while (pending_results.size() != 0)
					@(posedge clk);
			end
			if (n % 120 == 0)
				fill_bias = $urandom_range(1);
			@(negedge clk);
			row_typed <= 1'b0;
			calm = (n >= CALM_FROM && n < CALM_TO);
			pick_item(fill_bias, act, addr, span);
			offer_item(act, addr, span);
		end
		@(negedge clk);
		s_tvalid <= 1'b0;
		calm = 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		drain_wait = 2 * LATENCY + 10;
		repeat (drain_wait) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
